// ----- src/bsc_pkg.sv -----
package bsc_pkg;

  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int TEMP_W = 15;
  localparam int PRES_W = 17;

  localparam int T_W    = 20;
  localparam int ACC_W  = 40;
  localparam int ST_W   = 36;
  localparam int MC_W   = 36;
  localparam int MP_W   = 24;
  localparam int PR_W   = MC_W + MP_W;

  localparam int T_REF_C        = 2000;
  localparam int T_LOW_C        = -1500;
  localparam int TEMP_LO        = -4000;
  localparam int TEMP_HI        = 8500;
  localparam int PRES_HI        = 120000;
  localparam int REF_SHIFT      = 8;
  localparam int T_SHIFT        = 23;
  localparam int OFF_BASE_SHIFT = 16;
  localparam int OFF_SHIFT      = 7;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int SENS_SHIFT     = 8;
  localparam int T2_SHIFT       = 31;
  localparam int P_MUL_SHIFT    = 21;
  localparam int P_SHIFT        = 15;

  localparam int K_OFF2_D  = 5;
  localparam int K_OFF2_E  = 7;
  localparam int K_SENS2_E = 11;

  typedef struct packed {
    logic [CAL_W-1:0] cal_sens;
    logic [CAL_W-1:0] cal_offset;
    logic [CAL_W-1:0] cal_sens_tempco;
    logic [CAL_W-1:0] cal_offset_tempco;
    logic [CAL_W-1:0] cal_ref_temp;
    logic [CAL_W-1:0] cal_temp_coeff;
    logic             second_order_on;
  } cal_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_st_t;

endpackage

// ----- src/bsc_if.sv -----
interface bsc_in_if;
  import bsc_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [RAW_W-1:0] raw_value;

  modport source (output valid, output func, output raw_value, input ready);
  modport sink (input valid, input func, input raw_value, output ready);
endinterface

interface bsc_out_if;
  import bsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [TEMP_W-1:0] temperature;
  logic [PRES_W-1:0]        pressure;

  modport source (output valid, output kind, output temperature, output pressure, input ready);
  modport sink (input valid, input kind, input temperature, input pressure, output ready);
endinterface

// ----- src/bsc_serial_mul.sv -----
module bsc_serial_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsc_pkg::MC_W-1:0]  mcand_i,
  input  logic [bsc_pkg::MP_W-1:0]  mplier_i,
  output bsc_pkg::mul_st_t          st_o,
  output logic [bsc_pkg::PR_W-1:0]  prod_o
);
  import bsc_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [PR_W-1:0] mc_q;
  logic [MP_W-1:0] mp_q;
  logic [PR_W-1:0] acc_q;
  logic            last;

  assign last = (mp_q[MP_W-1:1] == '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && last) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // shift-add: one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= PR_W'(mcand_i);
      mp_q  <= mplier_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign prod_o    = acc_q;

endmodule

// ----- src/bsc_core.sv -----
module bsc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsc_pkg::cal_t        cal_i,
  bsc_in_if.sink               in_i,
  bsc_out_if.source            out_o
);
  import bsc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_SAT   = 2'd3;

  localparam logic [3:0] OP_TCOEF = 4'd0;
  localparam logic [3:0] OP_OTC   = 4'd1;
  localparam logic [3:0] OP_STC   = 4'd2;
  localparam logic [3:0] OP_DSQ   = 4'd3;
  localparam logic [3:0] OP_DD5   = 4'd4;
  localparam logic [3:0] OP_ESQ   = 4'd5;
  localparam logic [3:0] OP_EE7   = 4'd6;
  localparam logic [3:0] OP_EE11  = 4'd7;
  localparam logic [3:0] OP_DTSQ  = 4'd8;
  localparam logic [3:0] OP_PRES  = 4'd9;

  localparam logic signed [T_W-1:0] T_REF   = T_W'(T_REF_C);
  localparam logic signed [T_W-1:0] T_LOW   = T_W'(T_LOW_C);
  localparam logic signed [T_W-1:0] T_SAT_LO = T_W'(TEMP_LO);
  localparam logic signed [T_W-1:0] T_SAT_HI = T_W'(TEMP_HI);
  localparam logic signed [ACC_W-1:0] ACC_SAT_HI =
    {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_SAT_LO = ~ACC_SAT_HI;

  logic [1:0] state_q, state_d;
  logic [3:0] op_q, op_d;

  logic                     kind_q;
  logic [RAW_W-1:0]         raw_q;
  logic                     dt_neg_q, dt_neg_d;
  logic [RAW_W-1:0]         dt_mag_q, dt_mag_d;
  logic signed [T_W-1:0]    t_q, t_d;
  logic signed [ACC_W-1:0]  off_q, off_d;
  logic signed [ACC_W-1:0]  sens_q, sens_d;
  logic [MC_W-1:0]          aux_q, aux_d;

  logic signed [ST_W-1:0]   offset_acc_q, offset_acc_d;
  logic signed [ST_W-1:0]   sens_acc_q, sens_acc_d;
  logic signed [TEMP_W-1:0] temp_held_q, temp_held_d;
  logic [PRES_W-1:0]        pressure_held_q, pressure_held_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_kind_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic [PRES_W-1:0]        out_pres_q;
  logic                     out_load;

  logic                     mul_start;
  logic [MC_W-1:0]          mul_mc;
  logic [MP_W-1:0]          mul_mp;
  mul_st_t                  mul_st;
  logic [PR_W-1:0]          prod;

  logic [RAW_W-1:0]         ref_full;
  logic [T_W-1:0]           d_mag;
  logic [T_W-1:0]           e_mag;
  logic [MC_W-1:0]          sens_mag;
  logic [T_W-1:0]           tx;
  logic [ACC_W-1:0]         ox;
  logic [ACC_W-1:0]         sx;
  logic [ACC_W-1:0]         qm;
  logic [ACC_W-1:0]         off_base;
  logic [ACC_W-1:0]         sens_base;
  logic signed [ACC_W:0]    pv;
  logic [ACC_W-P_SHIFT-1:0] pq;
  logic signed [TEMP_W-1:0] temp_sat;
  logic [PRES_W-1:0]        pres_sat;
  logic signed [ST_W-1:0]   off_sat;
  logic signed [ST_W-1:0]   sens_sat;
  logic                     in_acc;

  bsc_serial_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mc),
    .mplier_i (mul_mp),
    .st_o     (mul_st),
    .prod_o   (prod)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign mul_start  = (state_q == S_ISSUE);
  assign out_load   = (state_q == S_SAT) && (!out_valid_q || out_o.ready);

  assign ref_full  = RAW_W'(cal_i.cal_ref_temp) << REF_SHIFT;
  assign d_mag     = T_W'(T_REF - t_q);
  assign e_mag     = T_W'(T_LOW - t_q);
  assign sens_mag  = sens_acc_q[ST_W-1] ? MC_W'(~sens_acc_q + 1'b1) : MC_W'(sens_acc_q);
  assign tx        = T_W'(prod >> T_SHIFT);
  assign ox        = ACC_W'(prod >> OFF_SHIFT);
  assign sx        = ACC_W'(prod >> SENS_SHIFT);
  assign qm        = ACC_W'(prod >> P_MUL_SHIFT);
  assign off_base  = ACC_W'(cal_i.cal_offset) << OFF_BASE_SHIFT;
  assign sens_base = ACC_W'(cal_i.cal_sens) << SENS_BASE_SHIFT;

  always_comb begin
    mul_mc = '0;
    mul_mp = '0;
    case (op_q)
      OP_TCOEF: begin
        mul_mc = MC_W'(dt_mag_q);
        mul_mp = MP_W'(cal_i.cal_temp_coeff);
      end
      OP_OTC: begin
        mul_mc = MC_W'(dt_mag_q);
        mul_mp = MP_W'(cal_i.cal_offset_tempco);
      end
      OP_STC: begin
        mul_mc = MC_W'(dt_mag_q);
        mul_mp = MP_W'(cal_i.cal_sens_tempco);
      end
      OP_DSQ: begin
        mul_mc = MC_W'(d_mag);
        mul_mp = MP_W'(d_mag);
      end
      OP_DD5: begin
        mul_mc = aux_q;
        mul_mp = MP_W'(K_OFF2_D);
      end
      OP_ESQ: begin
        mul_mc = MC_W'(e_mag);
        mul_mp = MP_W'(e_mag);
      end
      OP_EE7: begin
        mul_mc = aux_q;
        mul_mp = MP_W'(K_OFF2_E);
      end
      OP_EE11: begin
        mul_mc = aux_q;
        mul_mp = MP_W'(K_SENS2_E);
      end
      OP_DTSQ: begin
        mul_mc = MC_W'(dt_mag_q);
        mul_mp = dt_mag_q;
      end
      OP_PRES: begin
        mul_mc = sens_mag;
        mul_mp = raw_q;
      end
      default: begin
        mul_mc = '0;
        mul_mp = '0;
      end
    endcase
  end

  // result saturation
  always_comb begin
    if (t_q < T_SAT_LO) begin
      temp_sat = TEMP_W'(T_SAT_LO);
    end else if (t_q > T_SAT_HI) begin
      temp_sat = TEMP_W'(T_SAT_HI);
    end else begin
      temp_sat = TEMP_W'(t_q);
    end

    if (off_q > ACC_SAT_HI) begin
      off_sat = ST_W'(ACC_SAT_HI);
    end else if (off_q < ACC_SAT_LO) begin
      off_sat = ST_W'(ACC_SAT_LO);
    end else begin
      off_sat = ST_W'(off_q);
    end

    if (sens_q > ACC_SAT_HI) begin
      sens_sat = ST_W'(ACC_SAT_HI);
    end else if (sens_q < ACC_SAT_LO) begin
      sens_sat = ST_W'(ACC_SAT_LO);
    end else begin
      sens_sat = ST_W'(sens_q);
    end

    pv = $signed({off_q[ACC_W-1], off_q})
       - $signed({{(ACC_W+1-ST_W){offset_acc_q[ST_W-1]}}, offset_acc_q});
    pq = pv[ACC_W-1:P_SHIFT];
    if (pv[ACC_W]) begin
      pres_sat = '0;
    end else if (pq > (ACC_W-P_SHIFT)'(PRES_HI)) begin
      pres_sat = PRES_W'(PRES_HI);
    end else begin
      pres_sat = PRES_W'(pq);
    end
  end

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    dt_neg_d        = dt_neg_q;
    dt_mag_d        = dt_mag_q;
    t_d             = t_q;
    off_d           = off_q;
    sens_d          = sens_q;
    aux_d           = aux_q;
    offset_acc_d    = offset_acc_q;
    sens_acc_d      = sens_acc_q;
    temp_held_d     = temp_held_q;
    pressure_held_d = pressure_held_q;
    out_valid_d     = out_valid_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dt_neg_d = (in_i.raw_value < ref_full);
          dt_mag_d = dt_neg_d ? (ref_full - in_i.raw_value) : (in_i.raw_value - ref_full);
          op_d     = in_i.func ? OP_PRES : OP_TCOEF;
          state_d  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mul_st.done) begin
          state_d = S_ISSUE;
          case (op_q)
            OP_TCOEF: begin
              t_d  = dt_neg_q ? (T_REF - $signed(tx)) : (T_REF + $signed(tx));
              op_d = OP_OTC;
            end
            OP_OTC: begin
              off_d = dt_neg_q ? (off_base - ox) : (off_base + ox);
              op_d  = OP_STC;
            end
            OP_STC: begin
              sens_d = dt_neg_q ? (sens_base - sx) : (sens_base + sx);
              if (cal_i.second_order_on && (t_q < T_REF)) begin
                op_d = OP_DSQ;
              end else begin
                state_d = S_SAT;
              end
            end
            OP_DSQ: begin
              aux_d = MC_W'(prod);
              op_d  = OP_DD5;
            end
            OP_DD5: begin
              off_d  = off_q - ACC_W'(prod >> 1);
              sens_d = sens_q - ACC_W'(prod >> 2);
              op_d   = (t_q < T_LOW) ? OP_ESQ : OP_DTSQ;
            end
            OP_ESQ: begin
              aux_d = MC_W'(prod);
              op_d  = OP_EE7;
            end
            OP_EE7: begin
              off_d = off_q - ACC_W'(prod);
              op_d  = OP_EE11;
            end
            OP_EE11: begin
              sens_d = sens_q - ACC_W'(prod >> 1);
              op_d   = OP_DTSQ;
            end
            OP_DTSQ: begin
              t_d     = t_q - $signed(T_W'(prod >> T2_SHIFT));
              state_d = S_SAT;
            end
            OP_PRES: begin
              off_d   = sens_acc_q[ST_W-1] ? (~qm + 1'b1) : qm;
              state_d = S_SAT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SAT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (kind_q) begin
            pressure_held_d = pres_sat;
          end else begin
            offset_acc_d = off_sat;
            sens_acc_d   = sens_sat;
            temp_held_d  = temp_sat;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      op_q            <= OP_TCOEF;
      out_valid_q     <= 1'b0;
      offset_acc_q    <= '0;
      sens_acc_q      <= '0;
      temp_held_q     <= '0;
      pressure_held_q <= '0;
    end else begin
      state_q         <= state_d;
      op_q            <= op_d;
      out_valid_q     <= out_valid_d;
      offset_acc_q    <= offset_acc_d;
      sens_acc_q      <= sens_acc_d;
      temp_held_q     <= temp_held_d;
      pressure_held_q <= pressure_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_i.func;
      raw_q  <= in_i.raw_value;
    end
    dt_neg_q <= dt_neg_d;
    dt_mag_q <= dt_mag_d;
    t_q      <= t_d;
    off_q    <= off_d;
    sens_q   <= sens_d;
    aux_q    <= aux_d;
    if (out_load) begin
      out_kind_q <= kind_q;
      out_temp_q <= kind_q ? temp_held_q : temp_sat;
      out_pres_q <= kind_q ? pres_sat : pressure_held_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.temperature = out_temp_q;
  assign out_o.pressure    = out_pres_q;

`ifndef NO_ASSERTIONS
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy)
    else $error("multiplier started while busy");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> (state_q == S_WAIT))
    else $error("multiplier result outside wait state");

  a_accept_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_ISSUE))
    else $error("accepted transaction not issued");

  a_result_from_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_SAT))
    else $error("result loaded outside saturation step");

  a_pres_op_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ISSUE) && (op_q == OP_PRES)) |-> kind_q)
    else $error("pressure step on temperature transaction");
`endif

endmodule

// ----- src/baro_sensor_compensation.sv -----
// a pressure sample uses only the pressure multiply; a temperature sample runs the coefficient,
// offset and sensitivity tempco multiplies, plus second-order terms when enabled below T_REF
// the shared shift-add multiplier retires one multiplier bit per cycle for each multiply
// one sample in flight; the next is accepted once the result moves into the output register
// asynchronous active-low reset clears calibration words, stored offset and sensitivity
// and the held temperature and pressure
module baro_sensor_compensation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [bsc_pkg::CAL_W-1:0]  cfg_data_i,
  bsc_in_if.sink                     in_i,
  bsc_out_if.source                  out_o
);
  import bsc_pkg::*;

  localparam logic [2:0] CFG_SENS          = 3'd0;
  localparam logic [2:0] CFG_OFFSET        = 3'd1;
  localparam logic [2:0] CFG_SENS_TEMPCO   = 3'd2;
  localparam logic [2:0] CFG_OFFSET_TEMPCO = 3'd3;
  localparam logic [2:0] CFG_REF_TEMP      = 3'd4;
  localparam logic [2:0] CFG_TEMP_COEFF    = 3'd5;
  localparam logic [2:0] CFG_SECOND_ORDER  = 3'd6;

  cal_t cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SENS:          cal_q.cal_sens          <= cfg_data_i;
        CFG_OFFSET:        cal_q.cal_offset        <= cfg_data_i;
        CFG_SENS_TEMPCO:   cal_q.cal_sens_tempco   <= cfg_data_i;
        CFG_OFFSET_TEMPCO: cal_q.cal_offset_tempco <= cfg_data_i;
        CFG_REF_TEMP:      cal_q.cal_ref_temp      <= cfg_data_i;
        CFG_TEMP_COEFF:    cal_q.cal_temp_coeff    <= cfg_data_i;
        CFG_SECOND_ORDER:  cal_q.second_order_on   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  bsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cal_i  (cal_q),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
